FILE: src/tsg_pkg.sv
`timescale 1ns / 1ps

package tsg_pkg;

  localparam int TEMP_FRAC_BITS = 4;
  localparam int TEMP_W = 16;
  localparam int STOP_W = 8 + TEMP_FRAC_BITS;
  localparam int CMP_W = ((TEMP_W > STOP_W) ? TEMP_W : STOP_W) + 1;
  localparam int DEN_W = 8 + TEMP_FRAC_BITS;
  localparam int PROD_W = DEN_W + 8;
  localparam int NSUM_W = DEN_W + 10;
  localparam int REM_W = DEN_W + 7;
  localparam int QBITS = 6;
  localparam int CNT_W = $clog2(QBITS);
  localparam int PC_W = 4;
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_ENABLE,
    REG_LOW,
    REG_MID,
    REG_HIGH,
    REG_COLD,
    REG_BASE,
    REG_HOT
  } reg_e;

  typedef enum logic [1:0] {
    CH_R,
    CH_G,
    CH_B
  } chan_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLASS,
    OP_SETUP,
    OP_DIV,
    OP_FIN,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_NO_INPUT,
    J_DIRECT,
    J_CNT,
    J_OUT_BUSY
  } jmp_e;

  typedef struct packed {
    op_e              op;
    chan_e            ch;
    jmp_e             jmp;
    logic [PC_W-1:0]  target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic direct;
    logic cnt_more;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic        map_enable;
    logic [7:0]  low_temp;
    logic [7:0]  mid_temp;
    logic [7:0]  high_temp;
    logic [15:0] cold_rgb;
    logic [15:0] base_rgb;
    logic [15:0] hot_rgb;
  } cfg_t;

  localparam logic [PC_W-1:0] PC_WAIT  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_DIV_R = PC_W'(3);
  localparam logic [PC_W-1:0] PC_DIV_G = PC_W'(6);
  localparam logic [PC_W-1:0] PC_DIV_B = PC_W'(9);
  localparam logic [PC_W-1:0] PC_END   = PC_W'(11);

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, ch: CH_R, jmp: J_ALWAYS, target: PC_WAIT};
    case (pc)
      PC_W'(0):  w = '{op: OP_LOAD,  ch: CH_R, jmp: J_NO_INPUT, target: PC_WAIT};
      PC_W'(1):  w = '{op: OP_CLASS, ch: CH_R, jmp: J_DIRECT,   target: PC_END};
      PC_W'(2):  w = '{op: OP_SETUP, ch: CH_R, jmp: J_NEVER,    target: PC_WAIT};
      PC_W'(3):  w = '{op: OP_DIV,   ch: CH_R, jmp: J_CNT,      target: PC_DIV_R};
      PC_W'(4):  w = '{op: OP_FIN,   ch: CH_R, jmp: J_NEVER,    target: PC_WAIT};
      PC_W'(5):  w = '{op: OP_SETUP, ch: CH_G, jmp: J_NEVER,    target: PC_WAIT};
      PC_W'(6):  w = '{op: OP_DIV,   ch: CH_G, jmp: J_CNT,      target: PC_DIV_G};
      PC_W'(7):  w = '{op: OP_FIN,   ch: CH_G, jmp: J_NEVER,    target: PC_WAIT};
      PC_W'(8):  w = '{op: OP_SETUP, ch: CH_B, jmp: J_NEVER,    target: PC_WAIT};
      PC_W'(9):  w = '{op: OP_DIV,   ch: CH_B, jmp: J_CNT,      target: PC_DIV_B};
      PC_W'(10): w = '{op: OP_FIN,   ch: CH_B, jmp: J_NEVER,    target: PC_WAIT};
      PC_W'(11): w = '{op: OP_EMIT,  ch: CH_R, jmp: J_OUT_BUSY, target: PC_END};
      default:   w = '{op: OP_NOP,   ch: CH_R, jmp: J_ALWAYS,   target: PC_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [5:0] chan_of(input logic [15:0] color, input chan_e ch);
    logic [5:0] v;
    v = '0;
    unique case (ch)
      CH_R:    v = {1'b0, color[15:11]};
      CH_G:    v = color[10:5];
      CH_B:    v = {1'b0, color[4:0]};
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/tsg_if.sv
`timescale 1ns / 1ps

interface tsg_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] temp_sample;

  modport source (output valid, output req_type, output temp_sample, input ready);
  modport sink (input valid, input req_type, input temp_sample, output ready);
endinterface

interface tsg_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] color_out;
  logic        temp_seen;

  modport source (output valid, output color_out, output temp_seen, input ready);
  modport sink (input valid, input color_out, input temp_seen, output ready);
endinterface

FILE: src/tsg_regs.sv
`timescale 1ns / 1ps

module tsg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output tsg_pkg::cfg_t              cfg_o
);

  tsg_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [2:0]    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_enable <= 1'b1;
      cfg_q.low_temp   <= 8'd40;
      cfg_q.mid_temp   <= 8'd50;
      cfg_q.high_temp  <= 8'd60;
      cfg_q.cold_rgb   <= 16'h031F;
      cfg_q.base_rgb   <= 16'hA800;
      cfg_q.hot_rgb    <= 16'hFD00;
    end else if (wr_en) begin
      unique case (tsg_pkg::reg_e'(idx))
        tsg_pkg::REG_ENABLE: cfg_q.map_enable <= pwdata[0];
        tsg_pkg::REG_LOW:    cfg_q.low_temp   <= pwdata[7:0];
        tsg_pkg::REG_MID:    cfg_q.mid_temp   <= pwdata[7:0];
        tsg_pkg::REG_HIGH:   cfg_q.high_temp  <= pwdata[7:0];
        tsg_pkg::REG_COLD:   cfg_q.cold_rgb   <= pwdata[15:0];
        tsg_pkg::REG_BASE:   cfg_q.base_rgb   <= pwdata[15:0];
        tsg_pkg::REG_HOT:    cfg_q.hot_rgb    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (tsg_pkg::reg_e'(idx))
      tsg_pkg::REG_ENABLE: prdata = {31'd0, cfg_q.map_enable};
      tsg_pkg::REG_LOW:    prdata = {24'd0, cfg_q.low_temp};
      tsg_pkg::REG_MID:    prdata = {24'd0, cfg_q.mid_temp};
      tsg_pkg::REG_HIGH:   prdata = {24'd0, cfg_q.high_temp};
      tsg_pkg::REG_COLD:   prdata = {16'd0, cfg_q.cold_rgb};
      tsg_pkg::REG_BASE:   prdata = {16'd0, cfg_q.base_rgb};
      tsg_pkg::REG_HOT:    prdata = {16'd0, cfg_q.hot_rgb};
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: src/tsg_useq.sv
`timescale 1ns / 1ps

module tsg_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tsg_pkg::stat_t  stat_i,
  output tsg_pkg::ctrl_t  ctrl_o
);

  logic [tsg_pkg::PC_W-1:0] pc_q, pc_d;
  logic                     take;

  assign ctrl_o = tsg_pkg::ucode(pc_q);

  always_comb begin
    take = 1'b0;
    unique case (ctrl_o.jmp)
      tsg_pkg::J_NEVER:    take = 1'b0;
      tsg_pkg::J_ALWAYS:   take = 1'b1;
      tsg_pkg::J_NO_INPUT: take = !stat_i.in_valid;
      tsg_pkg::J_DIRECT:   take = stat_i.direct;
      tsg_pkg::J_CNT:      take = stat_i.cnt_more;
      tsg_pkg::J_OUT_BUSY: take = stat_i.out_busy;
      default:             take = 1'b1;
    endcase
    pc_d = take ? ctrl_o.target : pc_q + tsg_pkg::PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tsg_pkg::PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: src/tsg_dpath.sv
`timescale 1ns / 1ps

module tsg_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tsg_pkg::ctrl_t  ctrl_i,
  input  tsg_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  input  logic            req_type_i,
  input  logic [15:0]     temp_sample_i,
  input  logic            out_ready_i,
  output tsg_pkg::stat_t  stat_o,
  output logic            out_valid_o,
  output logic [15:0]     color_out_o,
  output logic            temp_seen_o
);

  localparam int CMP_W  = tsg_pkg::CMP_W;
  localparam int DEN_W  = tsg_pkg::DEN_W;
  localparam int PROD_W = tsg_pkg::PROD_W;
  localparam int NSUM_W = tsg_pkg::NSUM_W;
  localparam int REM_W  = tsg_pkg::REM_W;
  localparam int QBITS  = tsg_pkg::QBITS;
  localparam int CNT_W  = tsg_pkg::CNT_W;

  logic signed [15:0]       held_temp_q;
  logic                     held_valid_q;
  logic                     out_valid_q;
  logic [15:0]              color_q;
  logic                     seen_q;

  logic [15:0]              a_q, b_q, res_q;
  logic [DEN_W-1:0]         num_q, den_q;
  logic [REM_W-1:0]         rem_q;
  logic [QBITS-1:0]         quo_q;
  logic                     neg_q;
  logic [CNT_W-1:0]         cnt_q;

  logic signed [CMP_W-1:0]  t_ext, mn, md, mx, num_w, den_w;
  logic                     cls_direct;
  logic [15:0]              cls_color, cls_a, cls_b;

  logic [5:0]               a_ch, b_ch;
  logic signed [6:0]        diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [NSUM_W-1:0] nsum;
  logic [NSUM_W-1:0]        mag;
  logic [REM_W-1:0]         dsh;
  logic                     fit;
  logic [6:0]               qs, sum7;
  logic [15:0]              res_fin;
  logic                     out_busy;
  logic                     load;

  assign load = (ctrl_i.op == tsg_pkg::OP_LOAD) && in_valid_i;

  assign t_ext = CMP_W'(held_temp_q);
  assign mn = CMP_W'($signed(cfg_i.low_temp)) <<< tsg_pkg::TEMP_FRAC_BITS;
  assign md = CMP_W'($signed(cfg_i.mid_temp)) <<< tsg_pkg::TEMP_FRAC_BITS;
  assign mx = CMP_W'($signed(cfg_i.high_temp)) <<< tsg_pkg::TEMP_FRAC_BITS;

  always_comb begin
    cls_direct = 1'b1;
    cls_color  = cfg_i.base_rgb;
    cls_a      = cfg_i.cold_rgb;
    cls_b      = cfg_i.base_rgb;
    num_w      = t_ext - mn;
    den_w      = md - mn;
    if (!cfg_i.map_enable || !held_valid_q) begin
      cls_color = cfg_i.base_rgb;
    end else if (t_ext <= mn) begin
      cls_color = cfg_i.cold_rgb;
    end else if (t_ext >= mx) begin
      cls_color = cfg_i.hot_rgb;
    end else if (t_ext < md) begin
      cls_direct = 1'b0;
    end else begin
      cls_direct = 1'b0;
      cls_a      = cfg_i.base_rgb;
      cls_b      = cfg_i.hot_rgb;
      num_w      = t_ext - md;
      den_w      = mx - md;
    end
  end

  assign a_ch = tsg_pkg::chan_of(a_q, ctrl_i.ch);
  assign b_ch = tsg_pkg::chan_of(b_q, ctrl_i.ch);
  assign diff = $signed({1'b0, b_ch}) - $signed({1'b0, a_ch});
  assign prod = diff * $signed({1'b0, num_q});
  assign nsum = (NSUM_W'(prod) <<< 1) + NSUM_W'($signed({1'b0, den_q}));
  assign mag  = nsum[NSUM_W-1] ? NSUM_W'(-nsum) : NSUM_W'(nsum);

  assign dsh = REM_W'({den_q, 1'b0}) << cnt_q;
  assign fit = rem_q >= dsh;

  assign qs   = 7'(quo_q);
  assign sum7 = {1'b0, a_ch} + (neg_q ? (~qs + 7'd1) : qs);

  always_comb begin
    res_fin = res_q;
    unique case (ctrl_i.ch)
      tsg_pkg::CH_R: res_fin[15:11] = sum7[4:0];
      tsg_pkg::CH_G: res_fin[10:5]  = sum7[5:0];
      tsg_pkg::CH_B: res_fin[4:0]   = sum7[4:0];
      default:       res_fin        = res_q;
    endcase
  end

  assign out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_temp_q  <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (load && !req_type_i) begin
        held_temp_q  <= temp_sample_i;
        held_valid_q <= 1'b1;
      end
      if ((ctrl_i.op == tsg_pkg::OP_EMIT) && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl_i.op == tsg_pkg::OP_SETUP) begin
        cnt_q <= CNT_W'(QBITS - 1);
      end else if (ctrl_i.op == tsg_pkg::OP_DIV) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      tsg_pkg::OP_CLASS: begin
        res_q <= cls_color;
        a_q   <= cls_a;
        b_q   <= cls_b;
        num_q <= num_w[DEN_W-1:0];
        den_q <= den_w[DEN_W-1:0];
      end
      tsg_pkg::OP_SETUP: begin
        rem_q <= mag[REM_W-1:0];
        neg_q <= nsum[NSUM_W-1];
        quo_q <= '0;
      end
      tsg_pkg::OP_DIV: begin
        if (fit) begin
          rem_q <= rem_q - dsh;
        end
        quo_q <= {quo_q[QBITS-2:0], fit};
      end
      tsg_pkg::OP_FIN: res_q <= res_fin;
      tsg_pkg::OP_EMIT: begin
        if (!out_busy) begin
          color_q <= res_q;
          seen_q  <= held_valid_q;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.in_valid = in_valid_i;
  assign stat_o.direct   = cls_direct;
  assign stat_o.cnt_more = cnt_q != '0;
  assign stat_o.out_busy = out_busy;

  assign out_valid_o = out_valid_q;
  assign color_out_o = color_q;
  assign temp_seen_o = seen_q;

endmodule

FILE: src/three_stop_rgb565_gradient_top.sv
`timescale 1ns / 1ps
// Channel   Role    Handshake             Payload
// req_i     sink    valid/ready           req_type, temp_sample
// rsp_o     source  valid/ready           color_out, temp_seen
// apb       slave   psel/penable/pready   paddr, pwdata, prdata
//
// One transaction at a time, run by a microprogram.
// Disabled, no sample, or a temperature at or past the low or high stop: direct color, no divide.
// Blended: each channel goes through the shared restoring divider
// (6 quotient steps per channel, three channels in turn).
// Reset returns the configuration registers to defaults and clears the stored sample.
// A result held in the output register stalls the program at its emit step.

module three_stop_rgb565_gradient_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tsg_req_if.sink                    req_i,
  tsg_rsp_if.source                  rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tsg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  tsg_pkg::cfg_t  cfg;
  tsg_pkg::ctrl_t ctrl;
  tsg_pkg::stat_t stat;

  assign req_i.ready = (ctrl.op == tsg_pkg::OP_LOAD);

  tsg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsg_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  tsg_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg),
    .in_valid_i    (req_i.valid),
    .req_type_i    (req_i.req_type),
    .temp_sample_i (req_i.temp_sample),
    .out_ready_i   (rsp_o.ready),
    .stat_o        (stat),
    .out_valid_o   (rsp_o.valid),
    .color_out_o   (rsp_o.color_out),
    .temp_seen_o   (rsp_o.temp_seen)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_REFRESH = 1'b1;
  localparam int REG_SPARE = 7;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int HOLD_CYCLES = 300;
  localparam int END_CYCLES = 40;
  localparam tsg_pkg::cfg_t DEFAULT_CFG = '{
    map_enable: 1'b1, low_temp: 8'd40, mid_temp: 8'd50, high_temp: 8'd60,
    cold_rgb: 16'h031F, base_rgb: 16'hA800, hot_rgb: 16'hFD00
  };

  typedef struct packed {
    logic [15:0] color;
    logic        seen;
  } gradient_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [tsg_pkg::ADDR_W-1:0]  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  tsg_req_if req_if ();
  tsg_rsp_if rsp_if ();

  three_stop_rgb565_gradient_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  tsg_pkg::cfg_t      shadow_cfg;
  logic signed [15:0] held_temp;
  logic              held_valid;
  gradient_t         pending_colors[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int error_count;
  int checked_count;
  int blend_count;
  int config_writes;

  function automatic logic [15:0] blend_rgb565(input logic [15:0] a, input logic [15:0] b,
                                               input int num, input int den);
    int          shift [3] = '{11, 5, 0};
    int          mask [3] = '{31, 63, 31};
    int          ca;
    int          cb;
    int          q;
    logic [15:0] c;
    c = '0;
    for (int k = 0; k < 3; k++) begin
      ca = int'((a >> shift[k]) & mask[k]);
      cb = int'((b >> shift[k]) & mask[k]);
      q = (2 * (cb - ca) * num + den) / (2 * den);
      c = c | 16'(((ca + q) & mask[k]) << shift[k]);
    end
    return c;
  endfunction

  function automatic logic [15:0] gradient_color();
    int scale;
    int t;
    int lo;
    int md;
    int hi;
    scale = 1 << tsg_pkg::TEMP_FRAC_BITS;
    t = int'(held_temp);
    lo = int'($signed(shadow_cfg.low_temp)) * scale;
    md = int'($signed(shadow_cfg.mid_temp)) * scale;
    hi = int'($signed(shadow_cfg.high_temp)) * scale;
    if (!shadow_cfg.map_enable || !held_valid) return shadow_cfg.base_rgb;
    if (t <= lo) return shadow_cfg.cold_rgb;
    if (t >= hi) return shadow_cfg.hot_rgb;
    blend_count++;
    if (t < md) return blend_rgb565(shadow_cfg.cold_rgb, shadow_cfg.base_rgb, t - lo, md - lo);
    return blend_rgb565(shadow_cfg.base_rgb, shadow_cfg.hot_rgb, t - md, hi - md);
  endfunction

  function automatic gradient_t predict_gradient(input logic rtype, input logic [15:0] temp);
    gradient_t g;
    if (rtype == REQ_SAMPLE) begin
      held_temp = temp;
      held_valid = 1'b1;
    end
    g.color = gradient_color();
    g.seen = held_valid;
    return g;
  endfunction

  task automatic apb_write(input int idx, input logic [15:0] val);
    logic [31:0] wdata;
    wdata = ($urandom & 32'hFFFF_0000) | 32'(val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tsg_pkg::ADDR_W'(idx * 4);
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    config_writes++;
    case (idx)
      tsg_pkg::REG_ENABLE: shadow_cfg.map_enable = wdata[0];
      tsg_pkg::REG_LOW:    shadow_cfg.low_temp = wdata[7:0];
      tsg_pkg::REG_MID:    shadow_cfg.mid_temp = wdata[7:0];
      tsg_pkg::REG_HIGH:   shadow_cfg.high_temp = wdata[7:0];
      tsg_pkg::REG_COLD:   shadow_cfg.cold_rgb = wdata[15:0];
      tsg_pkg::REG_BASE:   shadow_cfg.base_rgb = wdata[15:0];
      tsg_pkg::REG_HOT:    shadow_cfg.hot_rgb = wdata[15:0];
      default: ;
    endcase
  endtask

  task automatic apb_read_check(input int idx, input logic [31:0] want);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= tsg_pkg::ADDR_W'(idx * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d read mismatch expected %h actual %h", $time,
               idx, want, prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_all_regs(input tsg_pkg::cfg_t c);
    apb_write(tsg_pkg::REG_ENABLE, 16'(c.map_enable));
    apb_write(tsg_pkg::REG_LOW, 16'(c.low_temp));
    apb_write(tsg_pkg::REG_MID, 16'(c.mid_temp));
    apb_write(tsg_pkg::REG_HIGH, 16'(c.high_temp));
    apb_write(tsg_pkg::REG_COLD, c.cold_rgb);
    apb_write(tsg_pkg::REG_BASE, c.base_rgb);
    apb_write(tsg_pkg::REG_HOT, c.hot_rgb);
  endtask

  task automatic send_req(input logic rtype, input logic [15:0] temp);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= rtype;
    req_if.temp_sample <= temp;
    do @(posedge clk_i); while (!req_if.ready);
    pending_colors.push_back(predict_gradient(rtype, temp));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default: begin send_idle_pct = 18; recv_stall_pct = 18; end
    endcase
  endtask

  function automatic logic [15:0] rand_temp();
    int lo;
    int hi;
    int a;
    int b;
    int c;
    a = int'($signed(shadow_cfg.low_temp));
    b = int'($signed(shadow_cfg.mid_temp));
    c = int'($signed(shadow_cfg.high_temp));
    lo = (a < b) ? a : b;
    lo = (lo < c) ? lo : c;
    hi = (a > b) ? a : b;
    hi = (hi > c) ? hi : c;
    lo = lo * 16 - 40;
    hi = hi * 16 + 40;
    if ($urandom_range(9) < 8) return 16'(lo + int'($urandom_range(hi - lo)));
    return 16'($urandom);
  endfunction

  task automatic test_defaults();
    set_idling(0);
    send_req(REQ_REFRESH, 16'($urandom));
    send_req(REQ_SAMPLE, 16'd0);
    send_req(REQ_SAMPLE, 16'd640);
    send_req(REQ_SAMPLE, 16'd641);
    send_req(REQ_SAMPLE, 16'd700);
    send_req(REQ_SAMPLE, 16'd799);
    send_req(REQ_SAMPLE, 16'd800);
    send_req(REQ_SAMPLE, 16'd801);
    send_req(REQ_SAMPLE, 16'd900);
    send_req(REQ_SAMPLE, 16'd959);
    send_req(REQ_SAMPLE, 16'd960);
    send_req(REQ_SAMPLE, 16'h7FFF);
    send_req(REQ_SAMPLE, 16'h8000);
    send_req(REQ_REFRESH, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_disable();
    apb_write(tsg_pkg::REG_ENABLE, 16'd0);
    send_req(REQ_SAMPLE, 16'd900);
    send_req(REQ_REFRESH, 16'd0);
    wait_drained();
    apb_write(tsg_pkg::REG_ENABLE, 16'd1);
    send_req(REQ_REFRESH, 16'd0);
    wait_drained();
  endtask

  task automatic test_stop_order();
    tsg_pkg::cfg_t c;
    // stops reversed
    c = DEFAULT_CFG;
    c.low_temp = 8'h7F;
    c.mid_temp = 8'h00;
    c.high_temp = 8'h80;
    write_all_regs(c);
    send_req(REQ_SAMPLE, 16'd100);
    send_req(REQ_SAMPLE, 16'd2040);
    wait_drained();
    // widest span, mid equal to high
    c = '{map_enable: 1'b1, low_temp: 8'h80, mid_temp: 8'h7F, high_temp: 8'h7F,
          cold_rgb: 16'h0000, base_rgb: 16'hFFFF, hot_rgb: 16'h0000};
    write_all_regs(c);
    send_req(REQ_SAMPLE, 16'd0);
    send_req(REQ_SAMPLE, 16'd2031);
    wait_drained();
    // low equal to mid
    c = '{map_enable: 1'b1, low_temp: 8'd10, mid_temp: 8'd10, high_temp: 8'd20,
          cold_rgb: 16'hFFFF, base_rgb: 16'h0000, hot_rgb: 16'hFFFF};
    write_all_regs(c);
    send_req(REQ_SAMPLE, 16'd200);
    wait_drained();
    apb_write(REG_SPARE, 16'hFFFF);
    send_req(REQ_REFRESH, 16'd0);
    wait_drained();
  endtask

  task automatic test_readback();
    apb_read_check(tsg_pkg::REG_ENABLE, {31'd0, shadow_cfg.map_enable});
    apb_read_check(tsg_pkg::REG_LOW, {24'd0, shadow_cfg.low_temp});
    apb_read_check(tsg_pkg::REG_MID, {24'd0, shadow_cfg.mid_temp});
    apb_read_check(tsg_pkg::REG_HIGH, {24'd0, shadow_cfg.high_temp});
    apb_read_check(tsg_pkg::REG_COLD, {16'd0, shadow_cfg.cold_rgb});
    apb_read_check(tsg_pkg::REG_BASE, {16'd0, shadow_cfg.base_rgb});
    apb_read_check(tsg_pkg::REG_HOT, {16'd0, shadow_cfg.hot_rgb});
    apb_read_check(REG_SPARE, 32'd0);
  endtask

  task automatic test_backpressure();
    set_idling(0);
    write_all_regs(DEFAULT_CFG);
    hold_request = HOLD_CYCLES;
    for (int k = 0; k < 8; k++) send_req(REQ_SAMPLE, 16'(650 + 35 * k));
    wait_drained();
  endtask

  task automatic program_random_cfg(input int kind);
    tsg_pkg::cfg_t c;
    logic [7:0]    s [3];
    logic [7:0]    tmp;
    c.map_enable = 1'b1;
    c.cold_rgb = 16'($urandom);
    c.base_rgb = 16'($urandom);
    c.hot_rgb = 16'($urandom);
    for (int k = 0; k < 3; k++) s[k] = 8'($urandom);
    case (kind)
      0: c = DEFAULT_CFG;
      1: begin
        s[0] = 8'h80;
        s[2] = 8'h7F;
        c.cold_rgb = 16'h0000;
        c.hot_rgb = 16'hFFFF;
      end
      2: begin
        for (int i = 0; i < 2; i++) begin
          for (int j = 0; j < 2 - i; j++) begin
            if ($signed(s[j]) > $signed(s[j+1])) begin
              tmp = s[j];
              s[j] = s[j+1];
              s[j+1] = tmp;
            end
          end
        end
        if ($urandom_range(2) == 0) s[1] = s[$urandom_range(1) * 2];
      end
      3: ;
      default: c.map_enable = 1'b0;
    endcase
    if (kind != 0) begin
      c.low_temp = s[0];
      c.mid_temp = s[1];
      c.high_temp = s[2];
    end
    write_all_regs(c);
  endtask

  task automatic test_random();
    logic rtype;
    for (int p = 0; p < PHASES; p++) begin
      program_random_cfg(p % 5);
      set_idling(p % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_drained();
        rtype = ($urandom_range(9) < 7) ? REQ_SAMPLE : REQ_REFRESH;
        send_req(rtype, (rtype == REQ_SAMPLE) ? rand_temp() : 16'($urandom));
      end
      wait_drained();
    end
  endtask

  // response side: random stalls plus an optional long hold-off
  initial begin
    int hold;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
        rsp_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    gradient_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected transaction color %h seen %b", $time,
                 rsp_if.color_out, rsp_if.temp_seen);
        error_count++;
      end else begin
        want = pending_colors.pop_front();
        checked_count++;
        if (rsp_if.color_out !== want.color) begin
          $display("%0t: color_out mismatch expected %h actual %h", $time,
                   want.color, rsp_if.color_out);
          error_count++;
        end
        if (rsp_if.temp_seen !== want.seen) begin
          $display("%0t: temp_seen mismatch expected %b actual %b", $time,
                   want.seen, rsp_if.temp_seen);
          error_count++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_SAMPLE;
    req_if.temp_sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    shadow_cfg = DEFAULT_CFG;
    held_temp = '0;
    held_valid = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    error_count = 0;
    checked_count = 0;
    blend_count = 0;
    config_writes = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_defaults();
    test_disable();
    test_stop_order();
    test_readback();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);
    if (pending_colors.size() != 0) begin
      $display("%0t: %0d transactions never returned", $time, pending_colors.size());
      error_count++;
    end
    $display("Checked %0d color transactions, %0d of them blended between stops,",
             checked_count, blend_count);
    $display("over %0d register writes and %0d errors.", config_writes, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
